/* rtl/tdb_pkg.sv */
// Shared widths, constants and helper functions for the dip and bend angle block.
package tdb_pkg;

	localparam int POS_W     = 24;                // position and momentum component width
	localparam int FLD_W     = 17;                // field register width
	localparam int DIP_W     = 16;
	localparam int BEND_W    = 15;
	localparam int SQ_W      = 48;                // sum of two squares
	localparam int RT_IN_W   = 64;                // square root radicand
	localparam int ROOT_W    = RT_IN_W / 2;
	localparam int REM_W     = ROOT_W + 3;
	localparam int RT_STEPS  = ROOT_W;            // one root bit per cell
	localparam int CW        = 36;                // rotator x and y width
	localparam int AW        = 32;                // angle accumulator, 30 fraction bits
	localparam int ITER_W    = 5;
	localparam int ANG_ITERS = 16;                // rotator iterations
	localparam int NDW       = 50;                // bend ratio numerator and denominator
	localparam int NORM_STEPS = 6;
	localparam int SH_W      = 6;
	localparam int NRM_W     = 30;                // normalized ratio width
	localparam int ANGLE_MAX = 25736;
	localparam logic [FLD_W-1:0] FIELD_RESET = 17'd5000;
	localparam logic [17:0] MEV_SCALE = 18'd256000;

	// arctangent of 2^-i, 30 fraction bits, truncated
	function automatic logic signed [AW-1:0] atan_q30(input logic [ITER_W-1:0] i);
		logic signed [AW-1:0] a;
		begin
			case (i)
				5'd0: a = 32'sd843314856;
				5'd1: a = 32'sd497837829;
				5'd2: a = 32'sd263043836;
				5'd3: a = 32'sd133525158;
				5'd4: a = 32'sd67021686;
				5'd5: a = 32'sd33543515;
				5'd6: a = 32'sd16775850;
				5'd7: a = 32'sd8388437;
				5'd8: a = 32'sd4194282;
				5'd9: a = 32'sd2097149;
				5'd10: a = 32'sd1048575;
				5'd11: a = 32'sd524287;
				5'd12: a = 32'sd262143;
				5'd13: a = 32'sd131071;
				5'd14: a = 32'sd65535;
				5'd15: a = 32'sd32767;
				5'd16: a = 32'sd16383;
				5'd17: a = 32'sd8191;
				5'd18: a = 32'sd4095;
				5'd19: a = 32'sd2047;
				5'd20: a = 32'sd1023;
				5'd21: a = 32'sd511;
				5'd22: a = 32'sd255;
				5'd23: a = 32'sd127;
				default: a = '0;
			endcase
			return a;
		end
	endfunction

	// round accumulator to 2^-14 rad and clamp
	function automatic logic signed [DIP_W-1:0] round_clamp(input logic signed [AW-1:0] acc);
		logic signed [AW-1:0] r;
		begin
			r = (acc + 32'sd32768) >>> 16;
			if (r > 32'sd25736)
				r = 32'sd25736;
			if (r < -32'sd25736)
				r = -32'sd25736;
			return r[DIP_W-1:0];
		end
	endfunction

endpackage

/* rtl/track_dip_and_bend_angle.sv */
// Top level: dip and bend angle of a track hit, fully pipelined.
// Throughput: one beat per cycle while the output is not stalled; every stage is a register with a shared enable.
// The chain is a row of registered arithmetic stages, root cells, rotator cells and normalize cells.
// Stall: when the output beat is held, the whole chain holds.
// Reset: arst_n clears all valid flags and loads field_strength with 5000.
module track_dip_and_bend_angle (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// pos_x[23:0], pos_y[47:24], pos_z[71:48], mom_x[95:72], mom_y[119:96], mom_z[143:120]
	input  logic [143:0]  s_tdata,
	// has_momentum[0]
	input  logic          s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// dip_angle[15:0], bend_angle[30:16], zero[31]
	output logic [31:0]   m_tdata,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [16:0]   cfg_data
);
	localparam int LAT     = 2 * tdb_pkg::RT_STEPS + tdb_pkg::ANG_ITERS
	                         + tdb_pkg::NORM_STEPS + 6;
	// dip result wait for the bend path
	localparam int DIP_DLY = tdb_pkg::RT_STEPS + tdb_pkg::NORM_STEPS + 3;
	// bend qualifier from normalize to output
	localparam int BOK_LEN = tdb_pkg::RT_STEPS + tdb_pkg::ANG_ITERS + tdb_pkg::NORM_STEPS + 2;

	typedef struct packed {
		logic                has_m;
		logic                r_zero;
		logic                p_zero;
		logic signed [23:0]  pz;
		logic signed [23:0]  mz;
	} side_t;

	logic                           en;
	logic [LAT-1:0]                 vld_q;
	logic [tdb_pkg::FLD_W-1:0]      field_q;
	logic                           field_pos;

	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = vld_q[LAT-1];
	assign field_pos = !field_q[tdb_pkg::FLD_W-1] && (field_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			field_q <= tdb_pkg::FIELD_RESET;
		end else begin
			if (en)
				vld_q <= {vld_q[LAT-2:0], s_tvalid};
			if (cfg_valid)
				field_q <= cfg_data;
		end
	end

	// stage 1: squares
	logic signed [23:0] px, py, mx, my;
	logic [46:0]        sq_px_s1, sq_py_s1, sq_mx_s1, sq_my_s1;
	side_t              side_s1;
	logic signed [47:0] p_px, p_py, p_mx, p_my;

	assign px   = s_tdata[23:0];
	assign py   = s_tdata[47:24];
	assign mx   = s_tdata[95:72];
	assign my   = s_tdata[119:96];
	assign p_px = px * px;
	assign p_py = py * py;
	assign p_mx = mx * mx;
	assign p_my = my * my;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_px_s1       <= p_px[46:0];
			sq_py_s1       <= p_py[46:0];
			sq_mx_s1       <= p_mx[46:0];
			sq_my_s1       <= p_my[46:0];
			side_s1.has_m  <= s_tuser;
			side_s1.r_zero <= 1'b0;
			side_s1.p_zero <= 1'b0;
			side_s1.pz     <= s_tdata[71:48];
			side_s1.mz     <= s_tdata[143:120];
		end
	end

	// stage 2: sums of squares
	logic [tdb_pkg::SQ_W-1:0] sr_s2, sp_s2;
	side_t                    side_s2;
	logic [tdb_pkg::SQ_W-1:0] sr_sum, sp_sum;

	assign sr_sum = tdb_pkg::SQ_W'(sq_px_s1) + tdb_pkg::SQ_W'(sq_py_s1);
	assign sp_sum = tdb_pkg::SQ_W'(sq_mx_s1) + tdb_pkg::SQ_W'(sq_my_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s2          <= sr_sum;
			sp_s2          <= sp_sum;
			side_s2.has_m  <= side_s1.has_m;
			side_s2.r_zero <= (sr_sum == '0);
			side_s2.p_zero <= (sp_sum == '0);
			side_s2.pz     <= side_s1.pz;
			side_s2.mz     <= side_s1.mz;
		end
	end

	// stages 3..34: radius and transverse momentum roots, side data alongside
	logic [tdb_pkg::RT_IN_W-1:0] rv   [tdb_pkg::RT_STEPS+1];
	logic [tdb_pkg::REM_W-1:0]   rrem [tdb_pkg::RT_STEPS+1];
	logic [tdb_pkg::ROOT_W-1:0]  rrt  [tdb_pkg::RT_STEPS+1];
	logic [tdb_pkg::RT_IN_W-1:0] pv   [tdb_pkg::RT_STEPS+1];
	logic [tdb_pkg::REM_W-1:0]   prem [tdb_pkg::RT_STEPS+1];
	logic [tdb_pkg::ROOT_W-1:0]  prt  [tdb_pkg::RT_STEPS+1];
	side_t                       side_q [tdb_pkg::RT_STEPS];

	assign rv[0]   = {sr_s2, 16'b0};
	assign rrem[0] = '0;
	assign rrt[0]  = '0;
	assign pv[0]   = {sp_s2, 16'b0};
	assign prem[0] = '0;
	assign prt[0]  = '0;

	for (genvar i = 0; i < tdb_pkg::RT_STEPS; i++) begin : g_rt1
		tdb_sqrt_cell u_rcell (
			.clk(clk), .en(en),
			.v_in(rv[i]), .rem_in(rrem[i]), .root_in(rrt[i]),
			.v_out(rv[i+1]), .rem_out(rrem[i+1]), .root_out(rrt[i+1])
		);
		tdb_sqrt_cell u_pcell (
			.clk(clk), .en(en),
			.v_in(pv[i]), .rem_in(prem[i]), .root_in(prt[i]),
			.v_out(pv[i+1]), .rem_out(prem[i+1]), .root_out(prt[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s2;
			for (int k = 1; k < tdb_pkg::RT_STEPS; k++)
				side_q[k] <= side_q[k-1];
		end
	end

	side_t                      sd;
	logic [tdb_pkg::ROOT_W-1:0] r_fx, pt_fx;

	assign sd    = side_q[tdb_pkg::RT_STEPS-1];
	assign r_fx  = rrt[tdb_pkg::RT_STEPS];
	assign pt_fx = prt[tdb_pkg::RT_STEPS];

	// dip rotator, stages 35..50, rounding at 51
	logic signed [tdb_pkg::CW-1:0] dx_c [tdb_pkg::ANG_ITERS+1];
	logic signed [tdb_pkg::CW-1:0] dy_c [tdb_pkg::ANG_ITERS+1];
	logic signed [tdb_pkg::AW-1:0] da_c [tdb_pkg::ANG_ITERS+1];
	logic [tdb_pkg::ANG_ITERS-1:0] dzero_q;

	assign dx_c[0] = sd.has_m ? tdb_pkg::CW'({1'b0, pt_fx}) : tdb_pkg::CW'({1'b0, r_fx});
	assign dy_c[0] = sd.has_m ? tdb_pkg::CW'(signed'({sd.mz, 8'b0}))
	                          : tdb_pkg::CW'(signed'({sd.pz, 8'b0}));
	assign da_c[0] = '0;

	for (genvar i = 0; i < tdb_pkg::ANG_ITERS; i++) begin : g_dip
		tdb_cordic_cell u_cell (
			.clk(clk), .en(en), .iter(tdb_pkg::ITER_W'(i)),
			.x_in(dx_c[i]), .y_in(dy_c[i]), .acc_in(da_c[i]),
			.x_out(dx_c[i+1]), .y_out(dy_c[i+1]), .acc_out(da_c[i+1])
		);
	end

	// without momentum, zero radius or zero z gives a dip of exactly zero; with momentum, zero pt or zero z does
	logic dzero_in;
	assign dzero_in = sd.has_m ? (sd.p_zero || sd.mz == '0) : (sd.r_zero || sd.pz == '0);

	logic signed [tdb_pkg::DIP_W-1:0] dip_q [DIP_DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			dzero_q  <= {dzero_q[tdb_pkg::ANG_ITERS-2:0], dzero_in};
			dip_q[0] <= dzero_q[tdb_pkg::ANG_ITERS-1] ? '0
			            : tdb_pkg::round_clamp(da_c[tdb_pkg::ANG_ITERS]);
			for (int k = 1; k < DIP_DLY; k++)
				dip_q[k] <= dip_q[k-1];
		end
	end

	// bend path stage 35: ratio numerator and denominator
	logic [tdb_pkg::NDW-1:0] n_s35, d_s35;
	logic                    ok_s35;
	logic [17:0]             b3;

	assign b3 = 18'(field_q[15:0]) + 18'({field_q[15:0], 1'b0});

	always_ff @(posedge clk) begin
		if (en) begin
			n_s35  <= tdb_pkg::NDW'(b3 * r_fx);
			d_s35  <= tdb_pkg::NDW'(tdb_pkg::MEV_SCALE * pt_fx);
			ok_s35 <= sd.has_m && !sd.p_zero && field_pos;
		end
	end

	// stages 36..41: left-justify d with n following
	logic [tdb_pkg::NDW-1:0] nd_d [tdb_pkg::NORM_STEPS+1];
	logic [tdb_pkg::NDW-1:0] nd_n [tdb_pkg::NORM_STEPS+1];
	logic [BOK_LEN-1:0]      bok_q;

	assign nd_d[0] = d_s35;
	assign nd_n[0] = n_s35;

	for (genvar i = 0; i < tdb_pkg::NORM_STEPS; i++) begin : g_norm
		tdb_norm_cell u_cell (
			.clk(clk), .en(en), .sh(tdb_pkg::SH_W'(32 >> i)),
			.d_in(nd_d[i]), .n_in(nd_n[i]),
			.d_out(nd_d[i+1]), .n_out(nd_n[i+1])
		);
	end

	// taking the top 30 bits equals the two-way shift into [2^29, 2^30)
	logic [tdb_pkg::NRM_W-1:0] dn, nn;
	assign dn = nd_d[tdb_pkg::NORM_STEPS][tdb_pkg::NDW-1 -: tdb_pkg::NRM_W];
	assign nn = nd_n[tdb_pkg::NORM_STEPS][tdb_pkg::NDW-1 -: tdb_pkg::NRM_W];

	// stage 42: squares, stage 43: difference
	logic [2*tdb_pkg::NRM_W-1:0] dd_s42, nsq_s42, diff_s43;
	logic [tdb_pkg::NRM_W-1:0]   nn_s42, nn_s43;

	always_ff @(posedge clk) begin
		if (en) begin
			dd_s42   <= dn * dn;
			nsq_s42  <= nn * nn;
			nn_s42   <= nn;
			diff_s43 <= dd_s42 - nsq_s42;
			nn_s43   <= nn_s42;
		end
	end

	// bend qualifier: field, momentum, hit inside radius, nonzero numerator
	always_ff @(posedge clk) begin
		if (en) begin
			bok_q[0] <= ok_s35 && (n_s35 < d_s35);
			for (int k = 1; k < BOK_LEN; k++) begin
				if (k == tdb_pkg::NORM_STEPS)
					bok_q[k] <= bok_q[k-1] && (nn != '0);
				else
					bok_q[k] <= bok_q[k-1];
			end
		end
	end

	// stages 44..75: cosine-side root
	logic [tdb_pkg::RT_IN_W-1:0] cv   [tdb_pkg::RT_STEPS+1];
	logic [tdb_pkg::REM_W-1:0]   crem [tdb_pkg::RT_STEPS+1];
	logic [tdb_pkg::ROOT_W-1:0]  crt  [tdb_pkg::RT_STEPS+1];
	logic [tdb_pkg::NRM_W-1:0]   nn_q [tdb_pkg::RT_STEPS];

	assign cv[0]   = tdb_pkg::RT_IN_W'(diff_s43);
	assign crem[0] = '0;
	assign crt[0]  = '0;

	for (genvar i = 0; i < tdb_pkg::RT_STEPS; i++) begin : g_rt2
		tdb_sqrt_cell u_cell (
			.clk(clk), .en(en),
			.v_in(cv[i]), .rem_in(crem[i]), .root_in(crt[i]),
			.v_out(cv[i+1]), .rem_out(crem[i+1]), .root_out(crt[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nn_q[0] <= nn_s43;
			for (int k = 1; k < tdb_pkg::RT_STEPS; k++)
				nn_q[k] <= nn_q[k-1];
		end
	end

	// stages 76..91: bend rotator
	logic signed [tdb_pkg::CW-1:0] bx_c [tdb_pkg::ANG_ITERS+1];
	logic signed [tdb_pkg::CW-1:0] by_c [tdb_pkg::ANG_ITERS+1];
	logic signed [tdb_pkg::AW-1:0] ba_c [tdb_pkg::ANG_ITERS+1];

	assign bx_c[0] = tdb_pkg::CW'(crt[tdb_pkg::RT_STEPS]);
	assign by_c[0] = tdb_pkg::CW'(nn_q[tdb_pkg::RT_STEPS-1]);
	assign ba_c[0] = '0;

	for (genvar i = 0; i < tdb_pkg::ANG_ITERS; i++) begin : g_bend
		tdb_cordic_cell u_cell (
			.clk(clk), .en(en), .iter(tdb_pkg::ITER_W'(i)),
			.x_in(bx_c[i]), .y_in(by_c[i]), .acc_in(ba_c[i]),
			.x_out(bx_c[i+1]), .y_out(by_c[i+1]), .acc_out(ba_c[i+1])
		);
	end

	// stage 92: output register
	logic signed [tdb_pkg::DIP_W-1:0] bend_r;
	logic [tdb_pkg::BEND_W-1:0]       bend_out;

	assign bend_r   = tdb_pkg::round_clamp(ba_c[tdb_pkg::ANG_ITERS]);
	assign bend_out = (bok_q[BOK_LEN-1] && bend_r > 0) ? bend_r[tdb_pkg::BEND_W-1:0] : '0;

	always_ff @(posedge clk) begin
		if (en)
			m_tdata <= {1'b0, bend_out, dip_q[DIP_DLY-1]};
	end
endmodule

/* rtl/tdb_sqrt_cell.sv */
// One cell of the pipelined integer square root: resolves one root bit.
module tdb_sqrt_cell (
	input  logic                            clk,
	input  logic                            en,
	input  logic [tdb_pkg::RT_IN_W-1:0]     v_in,
	input  logic [tdb_pkg::REM_W-1:0]       rem_in,
	input  logic [tdb_pkg::ROOT_W-1:0]      root_in,
	output logic [tdb_pkg::RT_IN_W-1:0]     v_out,
	output logic [tdb_pkg::REM_W-1:0]       rem_out,
	output logic [tdb_pkg::ROOT_W-1:0]      root_out
);
	logic [tdb_pkg::REM_W-1:0] rem_sh;
	logic [tdb_pkg::REM_W-1:0] trial;
	logic                      take;

	assign rem_sh = {rem_in[tdb_pkg::REM_W-3:0], v_in[tdb_pkg::RT_IN_W-1 -: 2]};
	assign trial  = tdb_pkg::REM_W'({root_in, 2'b01});
	assign take   = (rem_sh >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			v_out    <= {v_in[tdb_pkg::RT_IN_W-3:0], 2'b00};
			rem_out  <= take ? (rem_sh - trial) : rem_sh;
			root_out <= {root_in[tdb_pkg::ROOT_W-2:0], take};
		end
	end
endmodule

/* rtl/tdb_cordic_cell.sv */
// One vectoring rotator step with a fixed shift, registered.
module tdb_cordic_cell (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [tdb_pkg::ITER_W-1:0]           iter,
	input  logic signed [tdb_pkg::CW-1:0]        x_in,
	input  logic signed [tdb_pkg::CW-1:0]        y_in,
	input  logic signed [tdb_pkg::AW-1:0]        acc_in,
	output logic signed [tdb_pkg::CW-1:0]        x_out,
	output logic signed [tdb_pkg::CW-1:0]        y_out,
	output logic signed [tdb_pkg::AW-1:0]        acc_out
);
	logic signed [tdb_pkg::CW-1:0] dx;
	logic signed [tdb_pkg::CW-1:0] dy;
	logic signed [tdb_pkg::AW-1:0] ang;

	// arithmetic shift floors toward minus infinity
	assign dx  = y_in >>> iter;
	assign dy  = x_in >>> iter;
	assign ang = tdb_pkg::atan_q30(iter);

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_in > 0) begin
				x_out   <= x_in + dx;
				y_out   <= y_in - dy;
				acc_out <= acc_in + ang;
			end else begin
				x_out   <= x_in - dx;
				y_out   <= y_in + dy;
				acc_out <= acc_in - ang;
			end
		end
	end
endmodule

/* rtl/tdb_norm_cell.sv */
// One step of left-justifying the bend ratio pair by a fixed power of two.
module tdb_norm_cell (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tdb_pkg::SH_W-1:0]    sh,
	input  logic [tdb_pkg::NDW-1:0]     d_in,
	input  logic [tdb_pkg::NDW-1:0]     n_in,
	output logic [tdb_pkg::NDW-1:0]     d_out,
	output logic [tdb_pkg::NDW-1:0]     n_out
);
	logic top_clear;

	assign top_clear = ((d_in >> (tdb_pkg::SH_W'(tdb_pkg::NDW) - sh)) == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= top_clear ? (d_in << sh) : d_in;
			n_out <= top_clear ? (n_in << sh) : n_in;
		end
	end
endmodule

/* rtl/tdb_checker.sv */
// Port-level checks for the dip and bend angle block, bound to the top level.
module tdb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);
	// held output beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// a free output side never blocks the input side
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled with output free");

	a_dip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd25736)
		          && ($signed(m_tdata[15:0]) >= -16'sd25736))
		else $error("dip out of range");

	a_bend: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[30:16] <= 15'd25736) && !m_tdata[31])
		else $error("bend out of range");
endmodule

bind track_dip_and_bend_angle tdb_checker u_tdb_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

/* test/track_dip_and_bend_angle_tb.sv */
// Stream testbench for the track dip and bend angle block, checked against its own predictor.
module track_dip_and_bend_angle_tb;

	localparam int LATENCY   = 92;
	localparam int WDOG_MAX  = 20000;
	localparam int N_RANDOM  = 750;

	// idling phases: sender idle and receiver stall, percent
	localparam int N_PHASES = 4;
	int src_idle_pct [N_PHASES] = '{0, 83, 0, 22};
	int snk_stall_pct[N_PHASES] = '{0, 0, 83, 22};

	typedef struct packed {
		logic                             with_mom;
		logic signed [tdb_pkg::POS_W-1:0] px, py, pz, mx, my, mz;
	} hit_t;

	typedef struct packed {
		logic signed [tdb_pkg::DIP_W-1:0] dip;
		logic [tdb_pkg::BEND_W-1:0]       bend;
	} angles_t;

	// directed row: hit, whether the result is typed in, the typed result
	typedef struct {
		hit_t    hit;
		bit      typed;
		angles_t want;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [16:0]  cfg_data;

	track_dip_and_bend_angle i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// predictor copy of the field register
	logic signed [tdb_pkg::FLD_W-1:0] field_mt;
	angles_t pending_angles[$];
	bit      failed;
	int      stall_pct;
	int      wdog;

	// ---------------- predictor ----------------

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res, bit_w;
		res   = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v   = v - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	// arctangent of 2^-i, 30 fraction bits, truncated
	function automatic longint atan_step(input int i);
		longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
			262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
			255, 127};
		return tbl[i];
	endfunction

	// vectoring rotation: atan2(y, x) for x >= 0, 2^-14 rad, clamped
	function automatic longint vector_angle(input longint x, input longint y);
		longint acc, dx, dy;
		acc = 0;
		if (y == 0)
			return 0;
		for (int i = 0; i < tdb_pkg::ANG_ITERS; i++) begin
			dx = y >>> i;   // arithmetic shift floors
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; acc += atan_step(i);
			end else begin
				x -= dx; y += dy; acc -= atan_step(i);
			end
		end
		acc = (acc + (64'sd1 <<< 15)) >>> 16;
		if (acc > tdb_pkg::ANGLE_MAX) acc = tdb_pkg::ANGLE_MAX;
		if (acc < -tdb_pkg::ANGLE_MAX) acc = -tdb_pkg::ANGLE_MAX;
		return acc;
	endfunction

	function automatic angles_t track_angles(input hit_t h);
		longint px, py, pz, mx, my, mz, b, dip, bend;
		logic [63:0] s_r, s_p, r_fx, pt_fx, n, d, c;
		angles_t a;
		px = h.px; py = h.py; pz = h.pz;
		mx = h.mx; my = h.my; mz = h.mz;
		s_r = px * px + py * py;
		dip = 0; bend = 0;
		if (!h.with_mom) begin
			if (s_r != 0)
				dip = vector_angle(longint'(int_sqrt(s_r << 16)), pz * 256);
		end else begin
			s_p = mx * mx + my * my;
			if (s_p != 0) begin
				pt_fx = int_sqrt(s_p << 16);
				b     = field_mt;
				dip   = vector_angle(longint'(pt_fx), mz * 256);
				if (b > 0) begin
					r_fx = int_sqrt(s_r << 16);
					n = 64'd3 * b * r_fx;
					d = 64'd256000 * pt_fx;
					if (n < d) begin
						while (d >= (64'd1 << 30)) begin
							d = d >> 1; n = n >> 1;
						end
						while (d < (64'd1 << 29)) begin
							d = d << 1; n = n << 1;
						end
						c    = int_sqrt(d * d - n * n);
						bend = vector_angle(longint'(c), longint'(n));
						if (bend < 0) bend = 0;
					end
				end
			end
		end
		a.dip  = dip[tdb_pkg::DIP_W-1:0];
		a.bend = bend[tdb_pkg::BEND_W-1:0];
		return a;
	endfunction

	// ---------------- drivers ----------------

	// leaves s_tvalid high after the beat; the next call or the caller lowers it
	task automatic send_hit(input hit_t h, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= h.with_mom;
		s_tdata  <= {h.mz, h.my, h.mx, h.pz, h.py, h.px};
		pending_angles.push_back(track_angles(h));
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_field(input logic signed [tdb_pkg::FLD_W-1:0] v);
		s_tvalid <= 1'b0;
		// wait for the pipe to drain, then let any leftover work run out
		while (pending_angles.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		field_mt = v;
	endtask

	function automatic hit_t rand_hit();
		hit_t h;
		logic [159:0] rnd;
		int kind;
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
		h = rnd[$bits(hit_t)-1:0];
		kind = $urandom_range(9);
		// with momentum set, shrink the position and momentum so r < R is often met and bend is nonzero
		if (kind < 5) begin
			h.with_mom = 1'b1;
			h.px = $signed(h.px) >>> $urandom_range(23);
			h.py = $signed(h.py) >>> $urandom_range(23);
			h.pz = $signed(h.pz) >>> $urandom_range(23);
			h.mx = $signed(h.mx) >>> $urandom_range(16);
			h.my = $signed(h.my) >>> $urandom_range(16);
			h.mz = $signed(h.mz) >>> $urandom_range(23);
		end else if (kind == 5) begin
			h.mx = 0; h.my = 0;
		end else if (kind == 6) begin
			h.px = 0; h.py = 0;
		end
		return h;
	endfunction

	// ---------------- result checker ----------------

	always @(posedge clk) begin
		angles_t want, got;
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= stall_pct);
			if (m_tvalid && m_tready) begin
				got = {m_tdata[15:0], m_tdata[30:16]};
				if (pending_angles.size() == 0) begin
					$display("%0t: unexpected beat, actual %h", $time, m_tdata);
					failed = 1'b1;
				end else begin
					want = pending_angles.pop_front();
					if (got.dip !== want.dip) begin
						$display("%0t: dip_angle expected %0d actual %0d",
							$time, want.dip, got.dip);
						failed = 1'b1;
					end
					if (got.bend !== want.bend) begin
						$display("%0t: bend_angle expected %0d actual %0d",
							$time, want.bend, got.bend);
						failed = 1'b1;
					end
					if (m_tdata[31] !== 1'b0) begin
						$display("%0t: pad bit expected 0 actual %b", $time, m_tdata[31]);
						failed = 1'b1;
					end
				end
			end
		end
	end

	// watchdog: cycles with no beat on any channel while results are pending
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
				|| pending_angles.size() == 0)
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------- stimulus ----------------

	localparam logic signed [tdb_pkg::POS_W-1:0] PMAX = 24'sh7FFFFF;
	localparam logic signed [tdb_pkg::POS_W-1:0] PMIN = 24'sh800000;

	initial begin
		row_t rows[$];
		row_t rw;
		angles_t got;
		int phase, drain;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		failed    = 1'b0;
		stall_pct = 0;
		wdog      = 0;
		field_mt  = tdb_pkg::FIELD_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed results are the zero special cases
		rows = '{
			'{'{1'b0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0}},               // zero radius
			'{'{1'b0, 0, 0, PMAX, 5, 5, 5}, 1, '{0, 0}},            // zero radius, z set
			'{'{1'b1, 9, 9, 9, 0, 0, PMAX}, 1, '{0, 0}},            // zero pt
			'{'{1'b0, 100, 0, 0, 7, 7, 7}, 1, '{0, 0}},             // zero z
			'{'{1'b1, 0, 0, 0, 100, 0, 0}, 1, '{0, 0}},             // zero pz, zero r
			'{'{1'b1, PMAX, PMAX, 0, 1, 0, 0}, 1, '{0, 0}},         // beyond radius
			'{'{1'b0, PMAX, PMAX, PMAX, 0, 0, 0}, 0, '{0, 0}},
			'{'{1'b0, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN}, 0, '{0, 0}},
			'{'{1'b0, 1, 0, PMAX, 0, 0, 0}, 0, '{0, 0}},            // dip near +pi/2
			'{'{1'b0, 1, 0, PMIN, 0, 0, 0}, 0, '{0, 0}},            // dip near -pi/2
			'{'{1'b1, PMAX, PMIN, PMAX, PMAX, PMIN, PMAX}, 0, '{0, 0}},
			'{'{1'b1, PMIN, PMAX, PMIN, PMIN, PMAX, PMIN}, 0, '{0, 0}},
			'{'{1'b1, 256, 0, 0, 1000, 0, 1000}, 0, '{0, 0}},
			'{'{1'b1, 25600, 0, 0, 1000, 1000, -1000}, 0, '{0, 0}},
			'{'{1'b1, 1, 1, -1, PMAX, PMAX, 1}, 0, '{0, 0}},
			'{'{1'b1, -3, 4, 0, -30, 40, 0}, 0, '{0, 0}},
			'{'{1'b1, 700000, 0, 5, 40000, 0, -5}, 0, '{0, 0}}
		};
		foreach (rows[i]) begin
			rw = rows[i];
			send_hit(rw.hit, 0);
			if (rw.typed) begin
				got = pending_angles[pending_angles.size() - 1];
				if (got !== rw.want) begin
					$display("%0t: row %0d expected %h actual %h",
						$time, i, rw.want, got);
					failed = 1'b1;
				end
			end
		end

		// random part across field settings and idling phases
		for (int k = 0; k < N_RANDOM; k++) begin
			if (k % 75 == 0) begin
				case ((k / 75) % 6)
					0: write_field(17'sd65535);
					1: write_field(-17'sd65535);
					2: write_field(17'sd0);
					3: write_field(17'sd1);
					4: write_field(17'sd5000);
					default: write_field(17'($urandom));
				endcase
			end
			phase     = (k / 40) % N_PHASES;
			stall_pct = snk_stall_pct[phase];
			send_hit(rand_hit(), src_idle_pct[phase]);
		end
		s_tvalid <= 1'b0;

		drain = 0;
		while (pending_angles.size() != 0 && drain < 200000) begin
			@(posedge clk);
			drain++;
		end
		stall_pct = 0;
		repeat (LATENCY + 8) @(posedge clk);
		if (!failed && pending_angles.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/tdb_pkg.sv
rtl/tdb_sqrt_cell.sv
rtl/tdb_cordic_cell.sv
rtl/tdb_norm_cell.sv
rtl/track_dip_and_bend_angle.sv
rtl/tdb_checker.sv
test/track_dip_and_bend_angle_tb.sv
